// File: hw/rtl/bsc_pkg.sv
// Shared types, constants and coefficient layout for the compensation core.
`default_nettype none
package bsc_pkg;

  localparam int DIV_W = 64;

  localparam logic [2:0] CFG_TEMP    = 3'd0;
  localparam logic [2:0] CFG_PRESS_A = 3'd1;
  localparam logic [2:0] CFG_PRESS_B = 3'd2;
  localparam logic [2:0] CFG_PRESS_C = 3'd3;
  localparam logic [2:0] CFG_HUM_A   = 3'd4;
  localparam logic [2:0] CFG_HUM_B   = 3'd5;
  localparam logic [2:0] CFG_HUM_EN  = 3'd6;

  localparam logic signed [32:0] T_PRESS_OFS = 33'sd128000;
  localparam logic signed [31:0] T_HUM_OFS   = 32'sd76800;
  localparam logic signed [63:0] P_BIAS      = 64'sh0000_8000_0000_0000;
  localparam logic [20:0]        P_FULL      = 21'd1048576;
  localparam logic signed [13:0] P_SCALE     = 14'sd3125;
  localparam logic signed [31:0] H_MAX_Q     = 32'sd419430400;
  localparam logic [13:0]        H_MAX       = 14'd10000;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
    logic               hum_en;
  } bsc_coef_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic        [13:0] hum;
  } bsc_side_t;

endpackage
`default_nettype wire

// File: hw/rtl/bsc_front.sv
// Front pipeline: fine temperature, pressure numerator/divisor and humidity.
`default_nettype none
module bsc_front
  import bsc_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               adv_i,
  input  wire               valid_i,
  input  wire        [19:0] raw_pressure_i,
  input  wire        [19:0] raw_temperature_i,
  input  wire        [15:0] raw_humidity_i,
  input  bsc_coef_t         coef_i,
  output logic              valid_o,
  output logic signed [63:0] num_o,
  output logic signed [63:0] den_o,
  output bsc_side_t         side_o
);

  logic [11:0] vld_q;

  logic [19:0] ap_q [7];
  logic [15:0] ah_q [5];

  logic signed [31:0] ta_q, tdd_q, ta2_q, tb_q, tfine_q, tmul_q;
  logic signed [15:0] tsat_q [8];
  logic signed [32:0] v1_q;
  logic signed [63:0] sq_q, v2a_q, v1a_q, v2b_q, v1b_q, v2_q, v1c_q, v1d_q, n0_q;
  logic signed [48:0] m5_q, m2_q;
  logic signed [63:0] n_q [4];
  logic signed [63:0] d_q [4];
  logic signed [31:0] hx_q, hm5_q, hm6_q, hm3_q, hfa_q, hfb_q, hf1_q, hf2_q;
  logic signed [31:0] he_q [3];
  logic signed [31:0] hxx_q [3];
  logic signed [31:0] hss_q, hss7_q;
  logic        [13:0] hum_q;

  logic signed [31:0] t2_w, t3_w, ta_op, td_op, tv;
  logic signed [15:0] tsat_d;
  logic signed [65:0] sq_w;
  logic signed [79:0] v2a_w, v1a_w;
  logic signed [80:0] v1d_w;
  logic signed [77:0] n_w;
  logic signed [63:0] v1e;
  logic        [20:0] pdiff;
  logic signed [31:0] h2_w, h4_w, h5_w, h6_w, he_sum, hsh, hx12, hcl;
  logic        [26:0] hmul;
  logic        [16:0] hv;

  always_comb begin
    t2_w  = {{16{coef_i.t2[15]}}, coef_i.t2};
    t3_w  = {{16{coef_i.t3[15]}}, coef_i.t3};
    ta_op = $signed({15'd0, raw_temperature_i[19:3]}) - $signed({15'd0, coef_i.t1, 1'b0});
    td_op = $signed({16'd0, raw_temperature_i[19:4]}) - $signed({16'd0, coef_i.t1});
    tv    = tmul_q >>> 8;
    if (tv > 32'sd32767) begin
      tsat_d = 16'sh7fff;
    end else if (tv < -32'sd32768) begin
      tsat_d = 16'sh8000;
    end else begin
      tsat_d = tv[15:0];
    end
    sq_w  = v1_q * v1_q;
    v2a_w = sq_q * coef_i.p6;
    v1a_w = sq_q * coef_i.p3;
    v1e   = v1c_q + P_BIAS;
    v1d_w = v1e * $signed({1'b0, coef_i.p1});
    pdiff = P_FULL - {1'b0, ap_q[6]};
    n_w   = n0_q * P_SCALE;
    h2_w  = {{16{coef_i.h2[15]}}, coef_i.h2};
    h4_w  = {{20{coef_i.h4[11]}}, coef_i.h4};
    h5_w  = {{20{coef_i.h5[11]}}, coef_i.h5};
    h6_w  = {{24{coef_i.h6[7]}}, coef_i.h6};
    he_sum = $signed({2'd0, ah_q[4], 14'd0}) - (h4_w <<< 20) - hm5_q + 32'sd16384;
    hsh   = hxx_q[0] >>> 15;
    hx12  = hxx_q[2] - (hss7_q >>> 4);
    if (hx12 < 32'sd0) begin
      hcl = 32'sd0;
    end else if (hx12 > H_MAX_Q) begin
      hcl = H_MAX_Q;
    end else begin
      hcl = hx12;
    end
    hmul = 27'(hcl[31:12]) * 27'd100 + 27'd512;
    hv   = hmul[26:10];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[10:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ap_q[0] <= raw_pressure_i;
      for (int k = 1; k < 7; k++) ap_q[k] <= ap_q[k-1];
      ah_q[0] <= raw_humidity_i;
      for (int k = 1; k < 5; k++) ah_q[k] <= ah_q[k-1];
      // temperature
      ta_q    <= ta_op * t2_w;
      tdd_q   <= td_op * td_op;
      ta2_q   <= ta_q >>> 11;
      tb_q    <= (tdd_q >>> 12) * t3_w;
      tfine_q <= ta2_q + (tb_q >>> 14);
      tmul_q  <= tfine_q * 32'sd5 + 32'sd128;
      tsat_q[0] <= tsat_d;
      for (int k = 1; k < 8; k++) tsat_q[k] <= tsat_q[k-1];
      // pressure
      v1_q  <= $signed({tfine_q[31], tfine_q}) - T_PRESS_OFS;
      sq_q  <= sq_w[63:0];
      m5_q  <= v1_q * coef_i.p5;
      m2_q  <= v1_q * coef_i.p2;
      v2a_q <= v2a_w[63:0];
      v1a_q <= v1a_w[63:0];
      v2b_q <= ($signed({{15{m5_q[48]}}, m5_q}) <<< 17)
             + ($signed({{48{coef_i.p4[15]}}, coef_i.p4}) <<< 35);
      v1b_q <= $signed({{15{m2_q[48]}}, m2_q}) <<< 12;
      v2_q  <= v2a_q + v2b_q;
      v1c_q <= (v1a_q >>> 8) + v1b_q;
      v1d_q <= v1d_w[63:0];
      n0_q  <= $signed({12'd0, pdiff, 31'd0}) - v2_q;
      n_q[0] <= n_w[63:0];
      d_q[0] <= v1d_q >>> 33;
      for (int k = 1; k < 4; k++) begin
        n_q[k] <= n_q[k-1];
        d_q[k] <= d_q[k-1];
      end
      // humidity
      hx_q  <= tfine_q - T_HUM_OFS;
      hm5_q <= h5_w * hx_q;
      hm6_q <= hx_q * h6_w;
      hm3_q <= hx_q * $signed({24'd0, coef_i.h3});
      he_q[0] <= he_sum >>> 15;
      he_q[1] <= he_q[0];
      he_q[2] <= he_q[1];
      hfa_q <= hm6_q >>> 10;
      hfb_q <= (hm3_q >>> 11) + 32'sd32768;
      hf1_q <= hfa_q * hfb_q;
      hf2_q <= ((hf1_q >>> 10) + 32'sd2097152) * h2_w + 32'sd8192;
      hxx_q[0] <= he_q[2] * (hf2_q >>> 14);
      hxx_q[1] <= hxx_q[0];
      hxx_q[2] <= hxx_q[1];
      hss_q  <= hsh * hsh;
      hss7_q <= (hss_q >>> 7) * $signed({24'd0, coef_i.h1});
      if (!coef_i.hum_en) begin
        hum_q <= '0;
      end else if (hv > 17'(H_MAX)) begin
        hum_q <= H_MAX;
      end else begin
        hum_q <= hv[13:0];
      end
    end
  end

  assign valid_o     = vld_q[11];
  assign num_o       = n_q[3];
  assign den_o       = d_q[3];
  assign side_o.temp = tsat_q[7];
  assign side_o.hum  = hum_q;

endmodule
`default_nettype wire

// File: hw/rtl/bsc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
`default_nettype none
module bsc_div
  import bsc_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                adv_i,
  input  wire                valid_i,
  input  wire signed [63:0]  num_i,
  input  wire signed [63:0]  den_i,
  input  bsc_side_t          side_i,
  output logic               valid_o,
  output logic signed [63:0] quot_o,
  output logic               zero_o,
  output bsc_side_t          side_o
);

  logic [DIV_W+1:0]  vld_q;
  logic [DIV_W-1:0]  rem_q [DIV_W+1];
  logic [DIV_W-1:0]  nq_q  [DIV_W+1];
  logic [DIV_W-1:0]  den_q [DIV_W+1];
  logic              neg_q [DIV_W+1];
  logic              zr_q  [DIV_W+1];
  bsc_side_t         sd_q  [DIV_W+1];
  logic signed [63:0] quot_q;
  logic              zero_q;
  bsc_side_t         side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[DIV_W:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0] <= '0;
      nq_q[0]  <= num_i[63] ? 64'(-num_i) : num_i;
      den_q[0] <= den_i[63] ? 64'(-den_i) : den_i;
      neg_q[0] <= num_i[63] ^ den_i[63];
      zr_q[0]  <= (den_i == '0);
      sd_q[0]  <= side_i;
    end
  end

  for (genvar k = 0; k < DIV_W; k++) begin : g_step
    logic [DIV_W:0] r_sh;
    logic [DIV_W:0] r_nx;
    logic           ge;
    always_comb begin
      r_sh = {rem_q[k], nq_q[k][DIV_W-1]};
      ge   = (r_sh >= {1'b0, den_q[k]});
      r_nx = ge ? (r_sh - {1'b0, den_q[k]}) : r_sh;
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k+1] <= r_nx[DIV_W-1:0];
        nq_q[k+1]  <= {nq_q[k][DIV_W-2:0], ge};
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        zr_q[k+1]  <= zr_q[k];
        sd_q[k+1]  <= sd_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      quot_q <= neg_q[DIV_W] ? $signed(64'(-nq_q[DIV_W])) : $signed(nq_q[DIV_W]);
      zero_q <= zr_q[DIV_W];
      side_q <= sd_q[DIV_W];
    end
  end

  assign valid_o = vld_q[DIV_W+1];
  assign quot_o  = quot_q;
  assign zero_o  = zero_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

// File: hw/rtl/bsc_post.sv
// Pressure correction after the divide and the output register.
`default_nettype none
module bsc_post
  import bsc_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               adv_i,
  input  wire               valid_i,
  input  wire signed [63:0] quot_i,
  input  wire               zero_i,
  input  bsc_side_t         side_i,
  input  bsc_coef_t         coef_i,
  output logic              valid_o,
  output logic       [31:0] pres_o,
  output bsc_side_t         side_o
);

  logic [4:0] vld_q;
  logic signed [63:0] p_q [3];
  logic signed [63:0] q_q, t9_q, t8_q, v2_q [2], v1_q, s_q;
  logic [63:0] pa_q;
  logic [31:0] pb_q, pc_q;
  logic        zr_q [5];
  bsc_side_t   sd_q [5];
  logic [31:0] pres_q;

  logic signed [79:0] t9_w, t8_w;
  logic        [63:0] x9;
  logic signed [63:0] s_adj;

  always_comb begin
    t9_w  = coef_i.p9 * (quot_i >>> 13);
    t8_w  = coef_i.p8 * quot_i;
    x9    = pa_q + {pb_q + pc_q, 32'd0};
    s_adj = s_q[63] ? ((s_q + 64'sd255) >>> 8) : (s_q >>> 8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      zr_q[0] <= zero_i;
      sd_q[0] <= side_i;
      for (int k = 1; k < 5; k++) begin
        zr_q[k] <= zr_q[k-1];
        sd_q[k] <= sd_q[k-1];
      end
      p_q[0] <= quot_i;
      p_q[1] <= p_q[0];
      p_q[2] <= p_q[1];
      q_q    <= quot_i >>> 13;
      t9_q   <= t9_w[63:0];
      t8_q   <= t8_w[63:0];
      pa_q   <= t9_q[31:0] * q_q[31:0];
      pb_q   <= t9_q[31:0] * q_q[63:32];
      pc_q   <= t9_q[63:32] * q_q[31:0];
      v2_q[0] <= t8_q >>> 19;
      v2_q[1] <= v2_q[0];
      v1_q   <= $signed(x9) >>> 25;
      s_q    <= ((p_q[2] + v1_q + v2_q[1]) >>> 8)
              + ($signed({{48{coef_i.p7[15]}}, coef_i.p7}) <<< 4);
      pres_q <= zr_q[3] ? 32'd0 : s_adj[31:0];
    end
  end

  assign valid_o = vld_q[4];
  assign pres_o  = pres_q;
  assign side_o  = sd_q[4];

endmodule
`default_nettype wire

// File: hw/rtl/barometric_sensor_compensation_core.sv
// Top level: sensor reading compensation core with coefficient registers.
//
// Input channel: raw_pressure_i, raw_temperature_i, raw_humidity_i with
// in_valid_i / in_stall_o; a request is taken when valid is high and stall low.
// Output channel: temp_hundredths_o, pressure_in_pascal_o, humidity_hundredths_o
// with out_valid_o / out_stall_i; one result per input request, in order.
// Coefficients are written through cfg_valid_i / cfg_ready_o with cfg_index_i
// selecting the register; ready is always high. Write only while idle.
// Pipeline: 12 front stages, 66 divider stages and 5 correction stages lie
// between acceptance and result valid. Throughput: one request per cycle while
// out_stall_i does not hold the pipeline; the 64-stage divider array sets the depth.
// Reset clears all valid bits and coefficient registers.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
module barometric_sensor_compensation_core
  import bsc_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire        [19:0] raw_pressure_i,
  input  wire        [19:0] raw_temperature_i,
  input  wire        [15:0] raw_humidity_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic signed [15:0] temp_hundredths_o,
  output logic       [31:0] pressure_in_pascal_o,
  output logic       [13:0] humidity_hundredths_o,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire        [2:0]  cfg_index_i,
  input  wire        [47:0] cfg_data_i
);

  logic [47:0] temp_q, pa_q, pb_q, pc_q;
  logic [31:0] ha_q, hb_q;
  logic        hen_q;
  bsc_coef_t   coef;
  logic        adv;

  logic               f_vld, d_vld, p_vld, d_zero;
  logic signed [63:0] f_num, f_den, d_quot;
  bsc_side_t          f_side, d_side, p_side;
  logic        [31:0] p_pres;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      pc_q   <= '0;
      ha_q   <= '0;
      hb_q   <= '0;
      hen_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TEMP:    temp_q <= cfg_data_i;
        CFG_PRESS_A: pa_q   <= cfg_data_i;
        CFG_PRESS_B: pb_q   <= cfg_data_i;
        CFG_PRESS_C: pc_q   <= cfg_data_i;
        CFG_HUM_A:   ha_q   <= cfg_data_i[31:0];
        CFG_HUM_B:   hb_q   <= cfg_data_i[31:0];
        CFG_HUM_EN:  hen_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  assign coef.t1     = temp_q[15:0];
  assign coef.t2     = temp_q[31:16];
  assign coef.t3     = temp_q[47:32];
  assign coef.p1     = pa_q[15:0];
  assign coef.p2     = pa_q[31:16];
  assign coef.p3     = pa_q[47:32];
  assign coef.p4     = pb_q[15:0];
  assign coef.p5     = pb_q[31:16];
  assign coef.p6     = pb_q[47:32];
  assign coef.p7     = pc_q[15:0];
  assign coef.p8     = pc_q[31:16];
  assign coef.p9     = pc_q[47:32];
  assign coef.h1     = ha_q[7:0];
  assign coef.h2     = ha_q[23:8];
  assign coef.h3     = ha_q[31:24];
  assign coef.h4     = hb_q[11:0];
  assign coef.h5     = hb_q[23:12];
  assign coef.h6     = hb_q[31:24];
  assign coef.hum_en = hen_q;

  assign adv        = !(p_vld && out_stall_i);
  assign in_stall_o = !adv;

  bsc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .valid_i           (in_valid_i),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .raw_humidity_i    (raw_humidity_i),
    .coef_i            (coef),
    .valid_o           (f_vld),
    .num_o             (f_num),
    .den_o             (f_den),
    .side_o            (f_side)
  );

  bsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (f_vld),
    .num_i   (f_num),
    .den_i   (f_den),
    .side_i  (f_side),
    .valid_o (d_vld),
    .quot_o  (d_quot),
    .zero_o  (d_zero),
    .side_o  (d_side)
  );

  bsc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (d_vld),
    .quot_i  (d_quot),
    .zero_i  (d_zero),
    .side_i  (d_side),
    .coef_i  (coef),
    .valid_o (p_vld),
    .pres_o  (p_pres),
    .side_o  (p_side)
  );

  assign out_valid_o           = p_vld;
  assign temp_hundredths_o     = p_side.temp;
  assign pressure_in_pascal_o  = p_pres;
  assign humidity_hundredths_o = p_side.hum;

endmodule
`default_nettype wire

// File: sim/bsc_checker.sv
// Checker: predicts compensated readings and compares them with the core's results.
`timescale 1ns / 1ps
module bsc_checker
  import bsc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_stall_i,
  input  wire [19:0] raw_pressure_i,
  input  wire [19:0] raw_temperature_i,
  input  wire [15:0] raw_humidity_i,
  input  wire        out_valid_i,
  input  wire        out_stall_i,
  input  wire [15:0] temp_hundredths_i,
  input  wire [31:0] pressure_in_pascal_i,
  input  wire [13:0] humidity_hundredths_i,
  input  wire        cfg_valid_i,
  input  wire        cfg_ready_i,
  input  wire [2:0]  cfg_index_i,
  input  wire [47:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  typedef struct packed {
    logic [15:0] temp;
    logic [31:0] press;
    logic [13:0] hum;
  } reading_t;

  logic [47:0] temp_c, press_a, press_b, press_c;
  logic [31:0] hum_a, hum_b;
  logic        hum_en;
  reading_t    expected_q[$];

  function automatic reading_t compensate(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
    int t1, t2, t3, a, b, d, tfine, tv;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, q, num;
    int h1, h2, h3, h4, h5, h6, x, e, f, s, hum;
    reading_t r;
    t1 = temp_c[15:0];
    t2 = $signed(temp_c[31:16]);
    t3 = $signed(temp_c[47:32]);
    a = ((int'(rt >> 3) - (t1 << 1)) * t2) >>> 11;
    d = int'(rt >> 4) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    tfine = a + b;
    tv = (tfine * 5 + 128) >>> 8;
    if (tv < -32768) tv = -32768;
    if (tv > 32767) tv = 32767;
    r.temp = tv[15:0];

    p1 = press_a[15:0];
    p2 = $signed(press_a[31:16]);
    p3 = $signed(press_a[47:32]);
    p4 = $signed(press_b[15:0]);
    p5 = $signed(press_b[31:16]);
    p6 = $signed(press_b[47:32]);
    p7 = $signed(press_c[15:0]);
    p8 = $signed(press_c[31:16]);
    p9 = $signed(press_c[47:32]);
    v1 = longint'(tfine) - 128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
    v1 = (((longint'(1) << 47) + v1) * p1) >>> 33;
    r.press = '0;
    if (v1 != 0) begin
      p = 1048576 - longint'(rp);
      num = ((p << 31) - v2) * 3125;
      if (v1 == -1) p = -num;
      else p = num / v1;
      q = p >>> 13;
      v1 = (p9 * q * q) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 << 4);
      p = p / 256;
      r.press = p[31:0];
    end

    r.hum = '0;
    if (hum_en) begin
      h1 = hum_a[7:0];
      h2 = $signed(hum_a[23:8]);
      h3 = hum_a[31:24];
      h4 = $signed(hum_b[11:0]);
      h5 = $signed(hum_b[23:12]);
      h6 = $signed(hum_b[31:24]);
      x = tfine - 76800;
      e = ((int'(rh) << 14) - (h4 << 20) - h5 * x + 16384) >>> 15;
      f = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32768);
      f = (((f >>> 10) + 2097152) * h2 + 8192) >>> 14;
      x = e * f;
      s = x >>> 15;
      x = x - ((((s * s) >>> 7) * h1) >>> 4);
      if (x < 0) x = 0;
      if (x > 419430400) x = 419430400;
      hum = ((x >>> 12) * 100 + 512) / 1024;
      if (hum > 10000) hum = 10000;
      r.hum = hum[13:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      temp_c  <= '0;
      press_a <= '0;
      press_b <= '0;
      press_c <= '0;
      hum_a   <= '0;
      hum_b   <= '0;
      hum_en  <= 1'b0;
      fail_count_o = 0;
      checked_o = 0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TEMP:    temp_c  <= cfg_data_i;
          CFG_PRESS_A: press_a <= cfg_data_i;
          CFG_PRESS_B: press_b <= cfg_data_i;
          CFG_PRESS_C: press_c <= cfg_data_i;
          CFG_HUM_A:   hum_a   <= cfg_data_i[31:0];
          CFG_HUM_B:   hum_b   <= cfg_data_i[31:0];
          CFG_HUM_EN:  hum_en  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(compensate(raw_pressure_i, raw_temperature_i, raw_humidity_i));
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (temp_hundredths_i !== want.temp) begin
            $error("temp_hundredths expected %0d got %0d", $signed(want.temp),
                   $signed(temp_hundredths_i));
            fail_count_o++;
          end
          if (pressure_in_pascal_i !== want.press) begin
            $error("pressure_in_pascal expected %0d got %0d", want.press,
                   pressure_in_pascal_i);
            fail_count_o++;
          end
          if (humidity_hundredths_i !== want.hum) begin
            $error("humidity_hundredths expected %0d got %0d", want.hum,
                   humidity_hundredths_i);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the compensation core.
`timescale 1ns / 1ps
module tb_top;
  import bsc_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [19:0] raw_p = '0;
  logic [19:0] raw_t = '0;
  logic [15:0] raw_h = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  wire         in_stall, out_valid, cfg_ready;
  wire  [15:0] temp_o;
  wire  [31:0] press_o;
  wire  [13:0] hum_o;
  int          fail_count, pending, checked;
  int          cycles = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  bit          hold_go = 0;
  int          sent = 0;
  int          burst_left = 0;
  int          max_gap = 4;

  barometric_sensor_compensation_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .raw_pressure_i(raw_p), .raw_temperature_i(raw_t), .raw_humidity_i(raw_h),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .temp_hundredths_o(temp_o), .pressure_in_pascal_o(press_o),
    .humidity_hundredths_o(hum_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  bsc_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .raw_pressure_i(raw_p), .raw_temperature_i(raw_t), .raw_humidity_i(raw_h),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .temp_hundredths_i(temp_o), .pressure_in_pascal_i(press_o),
    .humidity_hundredths_i(hum_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stall pattern, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_go) begin
      hold_go = 0;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send(logic [19:0] p, logic [19:0] t, logic [15:0] h);
    bit taken;
    in_valid <= 1'b1;
    raw_p <= p;
    raw_t <= t;
    raw_h <= h;
    forever begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
      if (taken) break;
    end
    sent++;
  endtask

  task automatic send_bursty(logic [19:0] p, logic [19:0] t, logic [15:0] h);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(max_gap);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send(p, t, h);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(negedge clk_i);
      taken = cfg_ready;
      @(posedge clk_i);
      if (taken) break;
    end
  endtask

  task automatic load_coeffs(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                             logic [47:0] pc, logic [31:0] ha, logic [31:0] hb, bit en);
    write_reg(CFG_TEMP, tc);
    write_reg(CFG_PRESS_A, pa);
    write_reg(CFG_PRESS_B, pb);
    write_reg(CFG_PRESS_C, pc);
    write_reg(CFG_HUM_A, {16'h0, ha});
    write_reg(CFG_HUM_B, {16'h0, hb});
    write_reg(CFG_HUM_EN, {47'h0, en});
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // typical factory trim
  task automatic load_typical(bit en);
    load_coeffs({16'hFC18, 16'd26435, 16'd27504},
                {16'd3024, 16'hD643, 16'd36477},
                {16'hFFF9, 16'd140, 16'd2855},
                {16'd6000, 16'hC6F8, 16'd15500},
                {8'd0, 16'd362, 8'd75},
                {8'd30, 12'd50, 12'd313}, en);
  endtask

  task automatic random_items(int n, bit near_typical);
    repeat (n) begin
      if (near_typical && $urandom_range(3) != 0)
        send_bursty(20'($urandom_range(250000, 600000)),
                    20'($urandom_range(380000, 620000)),
                    16'($urandom_range(15000, 45000)));
      else
        send_bursty(20'($urandom), 20'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset coefficients: zero divisor, humidity off
    stall_pct = 0;
    max_gap = 0;
    send(20'h0, 20'h0, 16'h0);
    send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    drain();

    // directed pass with typical trim
    load_typical(1'b1);
    send(20'd415148, 20'd519888, 16'd30000);
    send(20'h0, 20'h0, 16'h0);
    send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send(20'h0, 20'hFFFFF, 16'h0);
    send(20'hFFFFF, 20'h0, 16'hFFFF);
    send(20'd415148, 20'd300000, 16'hFFFF);
    send(20'd415148, 20'd700000, 16'h0);
    send(20'd100000, 20'd519888, 16'd60000);
    drain();

    // extremes: all coefficient bits set, then the unused index
    load_coeffs('1, '1, '1, '1, '1, '1, 1'b1);
    write_reg(CFG_UNUSED, rand48());
    cfg_valid <= 1'b0;
    send(20'h0, 20'h0, 16'h0);
    send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send(20'h80000, 20'h80000, 16'h8000);
    drain();
    load_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'hFFFF},
                {16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000},
                {8'hFF, 16'h8000, 8'hFF}, {8'h80, 12'h7FF, 12'h800}, 1'b1);
    send(20'h0, 20'hFFFFF, 16'hFFFF);
    send(20'hFFFFF, 20'h0, 16'h0);
    drain();

    // random traffic, several trims and idle patterns
    load_typical(1'b1);
    stall_pct = 30;
    max_gap = 4;
    random_items(400, 1'b1);

    hold_go = 1;
    max_gap = 0;
    random_items(200, 1'b1);
    drain();

    load_typical(1'b0);
    stall_pct = 0;
    max_gap = 0;
    random_items(300, 1'b1);
    drain();

    load_coeffs(rand48(), rand48(), rand48(), rand48(), $urandom, $urandom, 1'b1);
    stall_pct = 70;
    max_gap = 8;
    random_items(300, 1'b0);
    drain();

    load_coeffs(rand48(), {rand48()} | 48'hFFFF, rand48(), rand48(), $urandom, $urandom,
                1'b1);
    stall_pct = 20;
    max_gap = 3;
    random_items(400, 1'b1);
    drain();

    load_typical(1'b1);
    stall_pct = 50;
    max_gap = 6;
    random_items(400, 1'b1);
    drain();

    $display("Sent %0d readings over several coefficient sets, %0d results compared.",
             sent, checked);
    $display("Included reset trim, all-ones trim, humidity off and a long output hold-off.");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
